[hdl/awr_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awr_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// adaptive window RMS core.
// -----------------------------------------------------------------------------
package awr_pkg;

  localparam int SAMPLE_W = 16;             // signed input sample
  localparam int FREQ_W   = 10;             // line frequency in Hz
  localparam int RMS_W    = 16;             // result width
  localparam int MAG_W    = SAMPLE_W + 1;   // magnitude holds 32768
  localparam int SQ_W     = 2 * MAG_W;      // square of the magnitude
  localparam int SUM_W    = 39;             // running sum of squares
  localparam int RAD_W    = SUM_W + 1;      // radicand padded to whole digit pairs
  localparam int ROOT_W   = RAD_W / 2;      // root bits, one per digit pair
  localparam int CNT_W    = $clog2(SUM_W);  // iteration counter, longest run SUM_W

  localparam int DEF_SAMPLE_RATE = 10000;
  localparam int DEF_MAX_WINDOW  = 256;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;         // capture sample magnitude and frequency
    logic check;        // compare frequency, clear on change, form the square
    logic wdiv_start;   // start SAMPLE_RATE / freq division
    logic win_load;     // clamp quotient into the window length
    logic acc;          // add square, bump count, flag a full window
    logic sdiv_start;   // start sum / window division
    logic div_step;     // one restoring divider iteration
    logic sqrt_start;   // load radicand from the quotient
    logic sqrt_step;    // one square root digit
    logic rms_load;     // keep the new RMS, clear running values
    logic out_load;     // fill the output register
  } awr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic freq_change;
    logic freq_zero;
    logic step_last;
    logic win_full;
  } awr_sts_t;

endpackage

[hdl/awr_in_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awr_in_if
// Sample channel: valid/ready handshake with one sample and its frequency.
// -----------------------------------------------------------------------------
interface awr_in_if;
  import awr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic        [FREQ_W-1:0]   freq_hz;

  modport source (output valid, output sample, output freq_hz, input ready);
  modport sink   (input valid, input sample, input freq_hz, output ready);

endinterface

[hdl/awr_out_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awr_out_if
// Result channel: valid/ready handshake with the RMS value and window flag.
// -----------------------------------------------------------------------------
interface awr_out_if;
  import awr_pkg::*;

  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_value;
  logic             window_done;

  modport source (output valid, output rms_value, output window_done, input ready);
  modport sink   (input valid, input rms_value, input window_done, output ready);

endinterface

[hdl/awr_dp.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awr_dp
// Datapath: running state, squarer, shared restoring divider, digit-by-digit
// square root and the output register.
// -----------------------------------------------------------------------------
module awr_dp #(
  parameter int SAMPLE_RATE = awr_pkg::DEF_SAMPLE_RATE,
  parameter int MAX_WINDOW  = awr_pkg::DEF_MAX_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  awr_pkg::awr_cmd_t                  cmd,
  output awr_pkg::awr_sts_t                  sts,
  input  logic signed [awr_pkg::SAMPLE_W-1:0] sample,
  input  logic        [awr_pkg::FREQ_W-1:0]   freq_hz,
  output logic        [awr_pkg::RMS_W-1:0]    rms_value,
  output logic                               window_done
);
  import awr_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int NUM_W = $clog2(SAMPLE_RATE + (1 << (FREQ_W - 1)));

  // captured item and square
  logic [FREQ_W-1:0] f_reg;
  logic [MAG_W-1:0]  mag;
  logic [SQ_W-1:0]   product;

  // running state
  logic [FREQ_W-1:0] last_freq;
  logic [SUM_W-1:0]  sum;
  logic [WIN_W-1:0]  count;
  logic [WIN_W-1:0]  window;
  logic              win_full;
  logic [RMS_W-1:0]  held_rms;

  // shared divider
  logic [SUM_W-1:0]  div_num;
  logic [FREQ_W-1:0] div_rem;
  logic [FREQ_W-1:0] div_den;

  // square root
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] sq_rem;
  logic [ROOT_W-1:0] root;

  logic [CNT_W-1:0]  step_cnt;

  // combinational helpers
  logic [MAG_W-1:0]  ext;
  logic [MAG_W-1:0]  abs_val;
  logic [FREQ_W:0]   div_trial;
  logic              div_fit;
  logic [FREQ_W:0]   div_diff;
  logic [FREQ_W-1:0] div_rem_next;
  logic [NUM_W-1:0]  num_win;
  logic [NUM_W-1:0]  quot;
  logic [WIN_W-1:0]  win_q;
  logic [WIN_W-1:0]  count_inc;
  logic [ROOT_W+1:0] sq_cat;
  logic [ROOT_W+1:0] sq_trial;
  logic              sq_fit;

  always_comb begin
    ext     = {sample[SAMPLE_W-1], sample};
    abs_val = ext[MAG_W-1] ? (~ext + 1'b1) : ext;

    div_trial    = {div_rem, div_num[SUM_W-1]};
    div_fit      = div_trial >= {1'b0, div_den};
    div_diff     = div_trial - {1'b0, div_den};
    div_rem_next = div_fit ? div_diff[FREQ_W-1:0] : div_trial[FREQ_W-1:0];

    num_win = NUM_W'(SAMPLE_RATE) + NUM_W'(f_reg >> 1);
    quot    = div_num[NUM_W-1:0];
    if (quot >= NUM_W'(MAX_WINDOW)) begin
      win_q = WIN_W'(MAX_WINDOW);
    end else if (quot == '0) begin
      win_q = WIN_W'(1);
    end else begin
      win_q = quot[WIN_W-1:0];
    end

    count_inc = count + 1'b1;

    sq_cat   = {sq_rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
    sq_trial = {root, 2'b01};
    sq_fit   = sq_cat >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_freq <= '0;
      sum       <= '0;
      count     <= '0;
      window    <= WIN_W'(MAX_WINDOW);
      held_rms  <= '0;
    end else begin
      if (cmd.check && sts.freq_change) begin
        last_freq <= f_reg;
        sum       <= '0;
        count     <= '0;
        if (sts.freq_zero) begin
          window <= WIN_W'(MAX_WINDOW);
        end
      end
      if (cmd.win_load) begin
        window <= win_q;
      end
      if (cmd.acc) begin
        sum   <= sum + SUM_W'(product);
        count <= count_inc;
      end
      if (cmd.rms_load) begin
        held_rms <= root[RMS_W-1:0];
        sum      <= '0;
        count    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      f_reg <= freq_hz;
      mag   <= abs_val;
    end
    if (cmd.check) begin
      product <= mag * mag;
    end
    if (cmd.acc) begin
      win_full <= count_inc >= window;
    end

    // shared divider: quotient bits enter at the bottom of div_num
    if (cmd.wdiv_start) begin
      div_num  <= {num_win, {(SUM_W - NUM_W){1'b0}}};
      div_den  <= f_reg;
      div_rem  <= '0;
      step_cnt <= CNT_W'(NUM_W - 1);
    end else if (cmd.sdiv_start) begin
      div_num  <= sum;
      div_den  <= FREQ_W'(window);
      div_rem  <= '0;
      step_cnt <= CNT_W'(SUM_W - 1);
    end else if (cmd.sqrt_start) begin
      step_cnt <= CNT_W'(ROOT_W - 1);
    end else if (cmd.div_step || cmd.sqrt_step) begin
      step_cnt <= step_cnt - 1'b1;
    end

    if (cmd.div_step) begin
      div_rem <= div_rem_next;
      div_num <= {div_num[SUM_W-2:0], div_fit};
    end

    if (cmd.sqrt_start) begin
      rad    <= RAD_W'(div_num);
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      rad    <= {rad[RAD_W-3:0], 2'b00};
      sq_rem <= sq_fit ? (sq_cat - sq_trial) : sq_cat;
      root   <= {root[ROOT_W-2:0], sq_fit};
    end

    if (cmd.out_load) begin
      rms_value   <= held_rms;
      window_done <= win_full;
    end
  end

  assign sts.freq_change = f_reg != last_freq;
  assign sts.freq_zero   = f_reg == '0;
  assign sts.step_last   = step_cnt == '0;
  assign sts.win_full    = win_full;

endmodule

[hdl/awr_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awr_ctrl
// Controller: sequences one item through the datapath and owns the
// channel handshakes.
// -----------------------------------------------------------------------------
module awr_ctrl (
  input  logic              clk,
  input  logic              rst,
  output awr_pkg::awr_cmd_t cmd,
  input  awr_pkg::awr_sts_t sts,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready
);
  import awr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_WDIV  = 4'd2;
  localparam logic [3:0] S_WIN   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_TEST  = 4'd5;
  localparam logic [3:0] S_SDIV  = 4'd6;
  localparam logic [3:0] S_SQLD  = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.freq_change && !sts.freq_zero) begin
          cmd.wdiv_start = 1'b1;
          state_next     = S_WDIV;
        end else begin
          state_next = S_ACC;
        end
      end
      S_WDIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        cmd.win_load = 1'b1;
        state_next   = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (sts.win_full) begin
          cmd.sdiv_start = 1'b1;
          state_next     = S_SDIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SDIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_next = S_SQLD;
        end
      end
      S_SQLD: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.rms_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        // hold until the previous result has gone
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/adaptive_window_rms_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// adaptive_window_rms_core
// RMS over one line period of a signed sample stream; window set from the
// measured frequency.
// -----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed sample and the line frequency in Hz per transfer.
//   out_ch returns one result per input: the latest window RMS and a flag that
//   is high when this sample closed a window.
//   One item is worked on at a time; in_ch.ready is high only while idle.
//   Steps per item, from input transfer to output valid: capture, frequency
//   check, accumulate, window test and output load; when the frequency
//   changes to a nonzero value, the bit-serial SAMPLE_RATE / freq division
//   and the window load come after the check; when the window closes, the
//   39-step sum / window division, the 20-digit square root and the RMS load
//   follow the window test, the root with its own registers and the divider's step counter.
//   The next input can be taken in the cycle after the result is loaded.
//   A result waits in the output register; the next item is accepted meanwhile
//   and is held at its last step until out_ch.ready takes the earlier one.
//   Synchronous reset clears the running sum, count, last frequency and RMS,
//   sets the window to MAX_WINDOW and empties the output register.
// -----------------------------------------------------------------------------
module adaptive_window_rms_core #(
  parameter int SAMPLE_RATE = awr_pkg::DEF_SAMPLE_RATE,
  parameter int MAX_WINDOW  = awr_pkg::DEF_MAX_WINDOW
) (
  input logic        clk,
  input logic        rst,
  awr_in_if.sink     in_ch,
  awr_out_if.source  out_ch
);
  import awr_pkg::*;

  awr_cmd_t cmd;
  awr_sts_t sts;

  awr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  awr_dp #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .sample      (in_ch.sample),
    .freq_hz     (in_ch.freq_hz),
    .rms_value   (out_ch.rms_value),
    .window_done (out_ch.window_done)
  );

endmodule

[hdl/awr_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awr_checker
// Port-level checks for the adaptive window RMS core, bound to the top level.
// -----------------------------------------------------------------------------
module awr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [awr_pkg::RMS_W-1:0]  rms_value,
  input logic                       window_done
);
  import awr_pkg::*;

  logic [RMS_W-1:0] last_rms;

  // RMS of the most recent transfer on the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rms <= '0;
    end else if (out_valid && out_ready) begin
      last_rms <= rms_value;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rms_value) && $stable(window_done))
    else $error("result dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_rms_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !window_done |-> rms_value == last_rms)
    else $error("RMS changed without a completed window");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind adaptive_window_rms_core awr_checker u_awr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .rms_value   (out_ch.rms_value),
  .window_done (out_ch.window_done)
);
